// ===== rtl/core/liked_and_recent_index_lists_defines.svh =====
// Assertion macros shared by the liked and recent index lists RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LIKED_AND_RECENT_INDEX_LISTS_DEFINES_SVH
`define LIKED_AND_RECENT_INDEX_LISTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lrl_pkg.sv =====
// Package for the liked and recent index lists block: sizes, codes and types.
// It depends on nothing and is used by lrl_seq, the top module and the testbench.
`timescale 1ns / 1ps

package lrl_pkg;

  localparam int LIKED_DEPTH  = 8;
  localparam int RECENT_DEPTH = 8;
  localparam int MAX_RESULTS  = 16;
  localparam int IDX_W        = 16;

  localparam int MAX_DEPTH = (LIKED_DEPTH > RECENT_DEPTH) ? LIKED_DEPTH : RECENT_DEPTH;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int LF_W      = $clog2(LIKED_DEPTH + 1);
  localparam int RF_W      = $clog2(RECENT_DEPTH + 1);
  localparam int L_AW      = (LIKED_DEPTH > 1) ? $clog2(LIKED_DEPTH) : 1;
  localparam int R_AW      = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int N_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CNT_W-1:0] L_DEPTH_C = CNT_W'(LIKED_DEPTH);
  localparam logic [CNT_W-1:0] R_DEPTH_C = CNT_W'(RECENT_DEPTH);
  localparam logic [N_W-1:0]   MAX_RES_C = N_W'(MAX_RESULTS);

  typedef enum logic [1:0] {
    MODE_RECORD  = 2'd0,
    MODE_LIKE    = 2'd1,
    MODE_DISLIKE = 2'd2,
    MODE_READ    = 2'd3
  } lrl_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_READ_RD,
    S_READ_EMIT,
    S_EMPTY
  } lrl_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             from_liked;
    logic             last;
    logic             lists_empty;
  } lrl_beat_t;

  typedef struct packed {
    logic             we;
    logic             to_liked;
    logic [CNT_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } lrl_wr_t;

endpackage

// ===== rtl/core/lrl_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// It depends on nothing.
`timescale 1ns / 1ps

module lrl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lrl_seq.sv =====
// Sequencer of the liked and recent index lists: fill counts, the shared
// address counter and comparator, and the read-out walk. Uses lrl_pkg and
// the assertion macros header.
`timescale 1ns / 1ps
`include "liked_and_recent_index_lists_defines.svh"

module lrl_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic [lrl_pkg::IDX_W-1:0]    in_item_index,
  output logic                         emit_valid,
  input  logic                         emit_ready,
  output lrl_pkg::lrl_beat_t           emit_beat,
  output lrl_pkg::lrl_wr_t             wr,
  output logic [lrl_pkg::CNT_W-1:0]    rd_addr,
  input  logic [lrl_pkg::IDX_W-1:0]    liked_rdata,
  input  logic [lrl_pkg::IDX_W-1:0]    recent_rdata
);
  import lrl_pkg::*;

  lrl_state_t       state_r, state_nxt;
  lrl_mode_t        mode_r, mode_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic             use_liked_r, use_liked_nxt;
  logic             shift_app_r, shift_app_nxt;
  logic [LF_W-1:0]  liked_fill_r, liked_fill_nxt;
  logic [RF_W-1:0]  recent_fill_r, recent_fill_nxt;

  logic [CNT_W-1:0] l_fill, r_fill, cur_fill, cur_depth, limit, k_inc;
  logic [IDX_W-1:0] cur_rdata;
  logic             full, hit, shift_more, read_last, both_empty;

  assign l_fill     = CNT_W'(liked_fill_r);
  assign r_fill     = CNT_W'(recent_fill_r);
  assign cur_fill   = use_liked_r ? l_fill : r_fill;
  assign cur_depth  = use_liked_r ? L_DEPTH_C : R_DEPTH_C;
  assign cur_rdata  = use_liked_r ? liked_rdata : recent_rdata;
  assign full       = (cur_fill == cur_depth);
  assign limit      = shift_app_r ? cur_depth : cur_fill;
  assign shift_more = (k_r < limit);
  assign k_inc      = k_r + CNT_W'(1);
  assign hit        = (recent_rdata == idx_r);
  assign both_empty = (liked_fill_r == '0) && (recent_fill_r == '0);
  assign read_last  = ((n_r + N_W'(1)) == MAX_RES_C) ||
                      (use_liked_r ? ((k_inc >= l_fill) && (recent_fill_r == '0))
                                   : (k_inc >= r_fill));
  assign rd_addr    = k_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (lrl_mode_t'(in_mode))
            MODE_RECORD:  state_nxt = S_APPEND;
            MODE_LIKE:    state_nxt = S_SCAN_RD;
            MODE_DISLIKE: state_nxt = S_SCAN_RD;
            MODE_READ:    state_nxt = both_empty ? S_EMPTY : S_READ_RD;
          endcase
        end
      end
      S_APPEND: state_nxt = full ? S_SHIFT_RD : S_IDLE;
      S_SHIFT_RD: begin
        priority if (shift_more) begin
          state_nxt = S_SHIFT_WR;
        end else if (!shift_app_r && mode_r == MODE_LIKE) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_SCAN_RD: begin
        priority if (k_r < r_fill) begin
          state_nxt = S_SCAN_CMP;
        end else if (mode_r == MODE_LIKE) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_CMP: state_nxt = hit ? S_SHIFT_RD : S_SCAN_RD;
      S_READ_RD: state_nxt = (use_liked_r && k_r >= l_fill) ? S_READ_RD : S_READ_EMIT;
      S_READ_EMIT: begin
        if (emit_ready) begin
          state_nxt = read_last ? S_IDLE : S_READ_RD;
        end
      end
      S_EMPTY: begin
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    emit_valid = 1'b0;
    emit_beat  = '0;
    wr         = '0;
    wr.to_liked = use_liked_r;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_APPEND: begin
        if (!full) begin
          wr.we   = 1'b1;
          wr.addr = cur_fill;
          wr.data = idx_r;
        end
      end
      S_SHIFT_RD: begin
        if (!shift_more && shift_app_r) begin
          wr.we   = 1'b1;
          wr.addr = cur_depth - CNT_W'(1);
          wr.data = idx_r;
        end
      end
      S_SHIFT_WR: begin
        wr.we   = 1'b1;
        wr.addr = k_r - CNT_W'(1);
        wr.data = cur_rdata;
      end
      S_READ_EMIT: begin
        emit_valid            = 1'b1;
        emit_beat.entry_index = cur_rdata;
        emit_beat.from_liked  = use_liked_r;
        emit_beat.last        = read_last;
      end
      S_EMPTY: begin
        emit_valid            = 1'b1;
        emit_beat.last        = 1'b1;
        emit_beat.lists_empty = 1'b1;
      end
      S_SCAN_RD, S_SCAN_CMP, S_READ_RD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mode_nxt        = mode_r;
    idx_nxt         = idx_r;
    k_nxt           = k_r;
    n_nxt           = n_r;
    use_liked_nxt   = use_liked_r;
    shift_app_nxt   = shift_app_r;
    liked_fill_nxt  = liked_fill_r;
    recent_fill_nxt = recent_fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt      = lrl_mode_t'(in_mode);
          idx_nxt       = in_item_index;
          k_nxt         = '0;
          n_nxt         = '0;
          shift_app_nxt = 1'b0;
          use_liked_nxt = (lrl_mode_t'(in_mode) == MODE_READ);
        end
      end
      S_APPEND: begin
        if (full) begin
          k_nxt         = CNT_W'(1);
          shift_app_nxt = 1'b1;
        end else if (use_liked_r) begin
          liked_fill_nxt = liked_fill_r + LF_W'(1);
        end else begin
          recent_fill_nxt = recent_fill_r + RF_W'(1);
        end
      end
      S_SHIFT_RD: begin
        if (!shift_more && !shift_app_r) begin
          recent_fill_nxt = recent_fill_r - RF_W'(1);
          use_liked_nxt   = 1'b1;
        end
      end
      S_SHIFT_WR: k_nxt = k_inc;
      S_SCAN_RD: begin
        if (k_r >= r_fill) begin
          use_liked_nxt = 1'b1;
        end
      end
      S_SCAN_CMP: k_nxt = k_inc;
      S_READ_RD: begin
        if (use_liked_r && k_r >= l_fill) begin
          use_liked_nxt = 1'b0;
          k_nxt         = '0;
        end
      end
      S_READ_EMIT: begin
        if (emit_ready) begin
          k_nxt = k_inc;
          n_nxt = n_r + N_W'(1);
        end
      end
      S_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      liked_fill_r  <= '0;
      recent_fill_r <= '0;
    end else begin
      state_r       <= state_nxt;
      liked_fill_r  <= liked_fill_nxt;
      recent_fill_r <= recent_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    use_liked_r <= use_liked_nxt;
    shift_app_r <= shift_app_nxt;
  end

  `LRL_ASSERT_NOW(a_fill_bound, 1'b1, (l_fill <= L_DEPTH_C) && (r_fill <= R_DEPTH_C), "fill count beyond depth")
  `LRL_ASSERT_NEXT(a_last_ends_read, emit_valid && emit_ready && emit_beat.last, state_r == S_IDLE, "read did not end after last beat")
  `LRL_ASSERT_NOW(a_no_write_idle, in_ready, !wr.we && !emit_valid, "store write or beat while idle")
  `LRL_ASSERT_NEXT(a_recent_shrink, state_r == S_SHIFT_RD && !shift_more && !shift_app_r, recent_fill_r == $past(recent_fill_r) - RF_W'(1), "remove did not shrink recent list")

endmodule

// ===== rtl/core/liked_and_recent_index_lists.sv =====
// Liked and recent index lists: two bounded lists of 16-bit item indices, kept
// oldest first, with record, like, dislike and read commands. Depends on lrl_pkg,
// lrl_seq and lrl_ram. The block takes a new item only while its sequencer is
// idle, and each item runs to completion before the next one is accepted. One
// address counter walks the two list memories and one 16-bit comparator checks
// the recent entries; each entry needs a read state and then a write, compare or
// emit state, because each memory has a single registered read port. A record
// appends to the recent list, or when it is full shifts the list down and writes
// the index at its tail. A dislike scans the recent list and removes the first
// entry equal to the index, if any. A like does the same and then appends the
// index to the liked list, shifting it down first when it is full. A read emits
// the liked entries and then the recent ones, at most 16 beats; it stalls while
// the output register is full and out_ready is low. An empty read emits one beat
// with last and lists_empty set. Each beat is taken into an output register that
// drives the out ports. Store contents are not cleared at reset; only the fill
// counts, sequencer state and output valid flag are, so it is ready at once.
`timescale 1ns / 1ps

module liked_and_recent_index_lists (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  input  logic [lrl_pkg::IDX_W-1:0] in_item_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lrl_pkg::IDX_W-1:0] out_entry_index,
  output logic                      out_from_liked,
  output logic                      out_last,
  output logic                      out_lists_empty
);
  import lrl_pkg::*;

  logic             emit_valid, emit_ready;
  lrl_beat_t        emit_beat;
  lrl_wr_t          wr;
  logic [CNT_W-1:0] rd_addr;
  logic [IDX_W-1:0] liked_rdata, recent_rdata;

  logic             out_valid_r, out_valid_nxt;
  lrl_beat_t        out_beat_r, out_beat_nxt;

  lrl_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_item_index(in_item_index),
    .emit_valid   (emit_valid),
    .emit_ready   (emit_ready),
    .emit_beat    (emit_beat),
    .wr           (wr),
    .rd_addr      (rd_addr),
    .liked_rdata  (liked_rdata),
    .recent_rdata (recent_rdata)
  );

  lrl_ram #(.WIDTH(IDX_W), .DEPTH(LIKED_DEPTH)) u_liked_ram (
    .clk  (clk),
    .we   (wr.we && wr.to_liked),
    .waddr(wr.addr[L_AW-1:0]),
    .wdata(wr.data),
    .raddr(rd_addr[L_AW-1:0]),
    .rdata(liked_rdata)
  );

  lrl_ram #(.WIDTH(IDX_W), .DEPTH(RECENT_DEPTH)) u_recent_ram (
    .clk  (clk),
    .we   (wr.we && !wr.to_liked),
    .waddr(wr.addr[R_AW-1:0]),
    .wdata(wr.data),
    .raddr(rd_addr[R_AW-1:0]),
    .rdata(recent_rdata)
  );

  assign emit_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (emit_ready) begin
      out_valid_nxt = emit_valid;
      out_beat_nxt  = emit_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_beat_r.entry_index;
  assign out_from_liked  = out_beat_r.from_liked;
  assign out_last        = out_beat_r.last;
  assign out_lists_empty = out_beat_r.lists_empty;

endmodule

// ===== dv/tb_liked_and_recent_index_lists.sv =====
// Self-checking testbench for liked_and_recent_index_lists: drives record, like,
// dislike and read items and checks every list beat against an in-bench predictor.
// Depends on lrl_pkg and the liked_and_recent_index_lists RTL.
`timescale 1ns / 1ps

module tb_liked_and_recent_index_lists;
  import lrl_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    lrl_mode_t        mode;
    logic [IDX_W-1:0] item_index;
  } play_event_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_mode = MODE_RECORD;
  logic [IDX_W-1:0] in_item_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] out_entry_index;
  logic             out_from_liked;
  logic             out_last;
  logic             out_lists_empty;

  play_event_t      pending_events[$];
  lrl_beat_t        expected_beats[$];
  logic [IDX_W-1:0] liked_list[$];
  logic [IDX_W-1:0] recent_model[$];

  bit in_taken = 1'b0;
  bit hold_off_request = 1'b0;
  int hold_left = 0;
  int idle_pct = 6;
  int errors = 0;
  int quiet_cycles = 0;
  int mode_count[4] = '{0, 0, 0, 0};
  int beats_checked = 0;
  int empty_reads = 0;

  liked_and_recent_index_lists uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_item_index  (in_item_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry_index(out_entry_index),
    .out_from_liked (out_from_liked),
    .out_last       (out_last),
    .out_lists_empty(out_lists_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic append_bounded(ref logic [IDX_W-1:0] list[$], input int depth,
                                input logic [IDX_W-1:0] idx);
    if (list.size() >= depth) begin
      void'(list.pop_front());
    end
    list.push_back(idx);
  endtask

  task automatic remove_first_recent(input logic [IDX_W-1:0] idx);
    for (int k = 0; k < recent_model.size(); k++) begin
      if (recent_model[k] == idx) begin
        recent_model.delete(k);
        return;
      end
    end
  endtask

  task automatic apply_play_event(input lrl_mode_t mode, input logic [IDX_W-1:0] idx);
    lrl_beat_t beats[$];
    lrl_beat_t b;
    case (mode)
      MODE_RECORD: begin
        append_bounded(recent_model, RECENT_DEPTH, idx);
      end
      MODE_LIKE: begin
        remove_first_recent(idx);
        append_bounded(liked_list, LIKED_DEPTH, idx);
      end
      MODE_DISLIKE: begin
        remove_first_recent(idx);
      end
      default: begin
        if (liked_list.size() == 0 && recent_model.size() == 0) begin
          b = '{entry_index: '0, from_liked: 1'b0, last: 1'b1, lists_empty: 1'b1};
          expected_beats.push_back(b);
          empty_reads++;
        end else begin
          foreach (liked_list[k]) begin
            if (beats.size() < MAX_RESULTS) begin
              b = '{entry_index: liked_list[k], from_liked: 1'b1, last: 1'b0,
                    lists_empty: 1'b0};
              beats.push_back(b);
            end
          end
          foreach (recent_model[k]) begin
            if (beats.size() < MAX_RESULTS) begin
              b = '{entry_index: recent_model[k], from_liked: 1'b0, last: 1'b0,
                    lists_empty: 1'b0};
              beats.push_back(b);
            end
          end
          beats[beats.size() - 1].last = 1'b1;
          foreach (beats[k]) expected_beats.push_back(beats[k]);
        end
      end
    endcase
  endtask

  // Input acceptance feeds the predictor; each output beat is checked against
  // the oldest expectation.
  always @(posedge clk) begin
    lrl_beat_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      apply_play_event(lrl_mode_t'(in_mode), in_item_index);
      mode_count[in_mode]++;
    end
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: entry_index %h from_liked %b last %b lists_empty %b",
               out_entry_index, out_from_liked, out_last, out_lists_empty);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_entry_index !== want.entry_index) begin
          $error("entry_index: expected %h, actual %h", want.entry_index, out_entry_index);
          errors++;
        end
        if (out_from_liked !== want.from_liked) begin
          $error("from_liked: expected %b, actual %b", want.from_liked, out_from_liked);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_last);
          errors++;
        end
        if (out_lists_empty !== want.lists_empty) begin
          $error("lists_empty: expected %b, actual %b", want.lists_empty, out_lists_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    play_event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        ev = pending_events.pop_front();
        in_valid <= 1'b1;
        in_mode <= ev.mode;
        in_item_index <= ev.item_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_request = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic queue_event(input lrl_mode_t mode, input logic [IDX_W-1:0] idx);
    play_event_t ev;
    ev.mode = mode;
    ev.item_index = idx;
    pending_events.push_back(ev);
  endtask

  task automatic queue_random_events(input int count);
    int pick;
    lrl_mode_t mode;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) mode = MODE_RECORD;
      else if (pick < 55) mode = MODE_LIKE;
      else if (pick < 78) mode = MODE_DISLIKE;
      else mode = MODE_READ;
      if ($urandom_range(0, 99) < 70) idx = IDX_W'($urandom_range(0, 15));
      else idx = IDX_W'($urandom_range(0, 65535));
      queue_event(mode, idx);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_events.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_event(MODE_READ, 16'h5a5a);
    queue_event(MODE_DISLIKE, 16'h0005);
    queue_event(MODE_LIKE, 16'hffff);
    queue_event(MODE_RECORD, 16'h0001);
    queue_event(MODE_RECORD, 16'h0002);
    queue_event(MODE_RECORD, 16'h0003);
    queue_event(MODE_RECORD, 16'h0003);
    queue_event(MODE_RECORD, 16'h0004);
    queue_event(MODE_RECORD, 16'h0005);
    queue_event(MODE_RECORD, 16'h0006);
    queue_event(MODE_RECORD, 16'h0007);
    queue_event(MODE_RECORD, 16'h0000);
    queue_event(MODE_DISLIKE, 16'h0003);
    queue_event(MODE_DISLIKE, 16'h0002);
    queue_event(MODE_LIKE, 16'h0000);
    queue_event(MODE_DISLIKE, 16'h1234);
    queue_event(MODE_READ, 16'hffff);
    for (int k = 0; k < 7; k++) begin
      queue_event(MODE_LIKE, 16'h8000 | IDX_W'(k));
    end
    queue_event(MODE_READ, 16'h0000);
    wait_until_drained();

    queue_random_events(200);
    while (pending_events.size() > 180) @(posedge clk);
    hold_off_request = 1'b1;
    wait_until_drained();

    idle_pct = 0;
    queue_random_events(150);
    wait_until_drained();

    idle_pct = 6;
    queue_random_events(105);
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d records, %0d likes, %0d dislikes and %0d reads (%0d empty).",
             mode_count[MODE_RECORD], mode_count[MODE_LIKE], mode_count[MODE_DISLIKE],
             mode_count[MODE_READ], empty_reads);
    $display("Checked %0d output beats, with a long output stall and an idle-free stretch.",
             beats_checked);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
